// ===== rtl/core/hnr_pkg.sv =====
// hnr_pkg: types and constants shared by the hamming ratio matcher
// used by hnr_popcnt, hnr_track and hamming_nn_ratio_match, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hnr_pkg;

    localparam int DESC_W  = 256;
    localparam int WORD_W  = 64;
    localparam int IDX_W   = 12;
    localparam int LVL_W   = 4;
    localparam int SLVL_W  = 5;
    localparam int DIST_W  = 9;
    localparam int RATIO_W = 9;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 9;

    localparam logic [DIST_W-1:0] NO_DIST    = 9'd256;
    localparam logic [SLVL_W-1:0] NONE_LEVEL = 5'h1F;

    localparam logic [DIST_W-1:0]  DIST_LIMIT_RST = 9'd100;
    localparam logic [RATIO_W-1:0] RATIO_Q8_RST   = 9'd230;

    // register indexes on the config port
    localparam logic [CIDX_W-1:0] CFG_DIST_LIMIT = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_RATIO_Q8   = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_RATIO_RULE = 8'd2;

    localparam logic RULE_STRICT = 1'b0;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_limit;
        logic [RATIO_W-1:0] ratio_q8;
        logic               ratio_rule;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] cand_index;
        logic [LVL_W-1:0] cand_level;
        logic             cand_skip;
        logic             last_candidate;
    } t_meta;

    typedef struct packed {
        logic              match_found;
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
        logic [DIST_W-1:0] second_distance;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/hnr_popcnt.sv =====
// hnr_popcnt: set-bit count of a 256-bit word through a byte adder tree
// uses hnr_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

module hnr_popcnt (
    input  wire logic [hnr_pkg::DESC_W-1:0] i_bits,
    output logic      [hnr_pkg::DIST_W-1:0] o_count
);

    logic [3:0] c1 [32];
    logic [4:0] c2 [16];
    logic [5:0] c3 [8];
    logic [6:0] c4 [4];
    logic [7:0] c5 [2];

    always_comb begin
        for (int b = 0; b < 32; b++) begin
            c1[b] = '0;
            for (int k = 0; k < 8; k++) begin
                c1[b] = c1[b] + 4'(i_bits[b*8+k]);
            end
        end
        for (int j = 0; j < 16; j++) begin
            c2[j] = 5'(c1[2*j]) + 5'(c1[2*j+1]);
        end
        for (int j = 0; j < 8; j++) begin
            c3[j] = 6'(c2[2*j]) + 6'(c2[2*j+1]);
        end
        for (int j = 0; j < 4; j++) begin
            c4[j] = 7'(c3[2*j]) + 7'(c3[2*j+1]);
        end
        for (int j = 0; j < 2; j++) begin
            c5[j] = 8'(c4[2*j]) + 8'(c4[2*j+1]);
        end
        o_count = 9'(c5[0]) + 9'(c5[1]);
    end

endmodule

`default_nettype wire

// ===== rtl/core/hnr_track.sv =====
// hnr_track: best and second-best search state plus the threshold and ratio decision
// uses hnr_pkg types and constants
`timescale 1ns / 1ps
`default_nettype none

module hnr_track (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [hnr_pkg::DIST_W-1:0] i_dist,
    input  wire hnr_pkg::t_meta             i_meta,
    input  wire hnr_pkg::t_cfg              i_cfg,
    output hnr_pkg::t_result                o_result
);

    logic [hnr_pkg::DIST_W-1:0] r_best_dist, n_best_dist;
    logic [hnr_pkg::DIST_W-1:0] r_second_dist, n_second_dist;
    logic [hnr_pkg::IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [hnr_pkg::SLVL_W-1:0] r_best_lvl, n_best_lvl;
    logic [hnr_pkg::SLVL_W-1:0] r_second_lvl, n_second_lvl;

    logic [hnr_pkg::DIST_W-1:0] upd_best_dist, upd_second_dist;
    logic [hnr_pkg::IDX_W-1:0]  upd_best_idx;
    logic [hnr_pkg::SLVL_W-1:0] upd_best_lvl, upd_second_lvl;
    logic [hnr_pkg::SLVL_W-1:0] lvl_ext;
    logic                       take_best, take_second;
    logic [17:0]                lhs, rhs;
    logic                       ok;

    always_comb begin
        lvl_ext     = hnr_pkg::SLVL_W'(i_meta.cand_level);
        take_best   = !i_meta.cand_skip && (i_dist < r_best_dist);
        take_second = !i_meta.cand_skip && !take_best && (i_dist < r_second_dist);

        upd_best_dist   = r_best_dist;
        upd_second_dist = r_second_dist;
        upd_best_idx    = r_best_idx;
        upd_best_lvl    = r_best_lvl;
        upd_second_lvl  = r_second_lvl;
        if (take_best) begin
            upd_second_dist = r_best_dist;
            upd_second_lvl  = r_best_lvl;
            upd_best_dist   = i_dist;
            upd_best_lvl    = lvl_ext;
            upd_best_idx    = i_meta.cand_index;
        end else if (take_second) begin
            upd_second_dist = i_dist;
            upd_second_lvl  = lvl_ext;
        end

        // best * 256 against ratio * second, exact
        lhs = 18'({upd_best_dist, 8'h00});
        rhs = 18'(i_cfg.ratio_q8) * 18'(upd_second_dist);

        ok = (upd_best_dist < hnr_pkg::NO_DIST) && (upd_best_dist <= i_cfg.distance_limit);
        if (ok) begin
            if (i_cfg.ratio_rule == hnr_pkg::RULE_STRICT) begin
                ok = lhs < rhs;
            end else if ((upd_best_lvl == upd_second_lvl) && (lhs > rhs)) begin
                ok = 1'b0;
            end
        end

        o_result.match_found     = ok;
        o_result.best_index      = ok ? upd_best_idx : '0;
        o_result.best_distance   = upd_best_dist;
        o_result.second_distance = upd_second_dist;

        // last beat of a query clears the search
        if (i_meta.last_candidate) begin
            n_best_dist   = hnr_pkg::NO_DIST;
            n_second_dist = hnr_pkg::NO_DIST;
            n_best_idx    = '0;
            n_best_lvl    = hnr_pkg::NONE_LEVEL;
            n_second_lvl  = hnr_pkg::NONE_LEVEL;
        end else begin
            n_best_dist   = upd_best_dist;
            n_second_dist = upd_second_dist;
            n_best_idx    = upd_best_idx;
            n_best_lvl    = upd_best_lvl;
            n_second_lvl  = upd_second_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist   <= hnr_pkg::NO_DIST;
            r_second_dist <= hnr_pkg::NO_DIST;
            r_best_idx    <= '0;
            r_best_lvl    <= hnr_pkg::NONE_LEVEL;
            r_second_lvl  <= hnr_pkg::NONE_LEVEL;
        end else if (i_step) begin
            r_best_dist   <= n_best_dist;
            r_second_dist <= n_second_dist;
            r_best_idx    <= n_best_idx;
            r_best_lvl    <= n_best_lvl;
            r_second_lvl  <= n_second_lvl;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hamming_nn_ratio_match.sv =====
// hamming_nn_ratio_match: one beat a cycle unless a stalled result holds the pipe, three-stage pipe
// output: a result reaches the result register once its last candidate beat has passed the xor and popcount registers
// throughput: one candidate beat per cycle; the whole pipe holds while a finished result is stalled at the output
// stages: input xor register, popcount register, search update into the result register
// reset: synchronous active low, clears the pipe, the search state and loads config defaults
`timescale 1ns / 1ps
`default_nettype none

module hamming_nn_ratio_match (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [hnr_pkg::WORD_W-1:0]    i_query_word0,
    input  wire logic [hnr_pkg::WORD_W-1:0]    i_query_word1,
    input  wire logic [hnr_pkg::WORD_W-1:0]    i_query_word2,
    input  wire logic [hnr_pkg::WORD_W-1:0]    i_query_word3,
    input  wire logic [hnr_pkg::WORD_W-1:0]    i_cand_word0,
    input  wire logic [hnr_pkg::WORD_W-1:0]    i_cand_word1,
    input  wire logic [hnr_pkg::WORD_W-1:0]    i_cand_word2,
    input  wire logic [hnr_pkg::WORD_W-1:0]    i_cand_word3,
    input  wire logic [hnr_pkg::IDX_W-1:0]     i_cand_index,
    input  wire logic [hnr_pkg::LVL_W-1:0]     i_cand_level,
    input  wire logic                          i_cand_skip,
    input  wire logic                          i_last_candidate,

    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_match_found,
    output logic      [hnr_pkg::IDX_W-1:0]     o_best_index,
    output logic      [hnr_pkg::DIST_W-1:0]    o_best_distance,
    output logic      [hnr_pkg::DIST_W-1:0]    o_second_distance,

    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [hnr_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [hnr_pkg::CDATA_W-1:0]   i_cfg_data
);

    logic                        adv;
    logic                        in_accept;

    logic                        r_s1_valid;
    logic [hnr_pkg::DESC_W-1:0]  r_s1_diff;
    hnr_pkg::t_meta              r_s1_meta;

    logic                        r_s2_valid;
    logic [hnr_pkg::DIST_W-1:0]  r_s2_dist;
    hnr_pkg::t_meta              r_s2_meta;

    logic [hnr_pkg::DIST_W-1:0]  s1_count;
    hnr_pkg::t_result            s2_result;

    logic                        r_out_valid;
    hnr_pkg::t_result            r_out;

    hnr_pkg::t_cfg               r_cfg;

    // pipe moves unless a finished result is held by the receiver
    assign adv         = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !adv;
    assign in_accept   = i_in_valid && adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_limit <= hnr_pkg::DIST_LIMIT_RST;
            r_cfg.ratio_q8       <= hnr_pkg::RATIO_Q8_RST;
            r_cfg.ratio_rule     <= hnr_pkg::RULE_STRICT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hnr_pkg::CFG_DIST_LIMIT: r_cfg.distance_limit <= i_cfg_data;
                hnr_pkg::CFG_RATIO_Q8:   r_cfg.ratio_q8       <= i_cfg_data;
                hnr_pkg::CFG_RATIO_RULE: r_cfg.ratio_rule     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= in_accept;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_meta.last_candidate;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_diff <= {i_query_word3 ^ i_cand_word3, i_query_word2 ^ i_cand_word2,
                          i_query_word1 ^ i_cand_word1, i_query_word0 ^ i_cand_word0};
            r_s1_meta.cand_index     <= i_cand_index;
            r_s1_meta.cand_level     <= i_cand_level;
            r_s1_meta.cand_skip      <= i_cand_skip;
            r_s1_meta.last_candidate <= i_last_candidate;
            r_s2_dist <= s1_count;
            r_s2_meta <= r_s1_meta;
            r_out     <= s2_result;
        end
    end

    hnr_popcnt u_popcnt (
        .i_bits  (r_s1_diff),
        .o_count (s1_count)
    );

    hnr_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv && r_s2_valid),
        .i_dist   (r_s2_dist),
        .i_meta   (r_s2_meta),
        .i_cfg    (r_cfg),
        .o_result (s2_result)
    );

    assign o_out_valid       = r_out_valid;
    assign o_match_found     = r_out.match_found;
    assign o_best_index      = r_out.best_index;
    assign o_best_distance   = r_out.best_distance;
    assign o_second_distance = r_out.second_distance;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for hamming_nn_ratio_match, stream of candidate beats against
// a cycle-free predictor of the best/second search and the ratio test; depends on hnr_pkg
`timescale 1ns / 1ps

module tb;
    import hnr_pkg::*;

    localparam logic RULE_LEVEL = 1'b1;
    localparam int   PHASE_BEATS = 250;
    localparam int   CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [DESC_W-1:0] query;
        logic [DESC_W-1:0] cand;
        t_meta             meta;
    } t_cand_beat;

    logic i_clk;
    logic rst_n = 1'b0;

    logic              in_valid  = 1'b0;
    t_cand_beat        drv       = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CIDX_W-1:0] cfg_idx   = '0;
    logic [CDATA_W-1:0] cfg_dat  = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_match_found;
    logic [IDX_W-1:0]  o_best_index;
    logic [DIST_W-1:0] o_best_distance;
    logic [DIST_W-1:0] o_second_distance;
    logic              o_cfg_ready;

    t_cand_beat cand_beats[$];
    t_result    want_matches[$];
    int         errors = 0;
    int         cycles = 0;
    int         send_idle = 35;
    int         recv_stall = 60;

    // predictor copy of the config and the search registers
    logic [DIST_W-1:0]  lim_cfg   = DIST_LIMIT_RST;
    logic [RATIO_W-1:0] ratio_cfg = RATIO_Q8_RST;
    logic               rule_cfg  = RULE_STRICT;
    logic [DIST_W-1:0]  best_d, second_d;
    logic [IDX_W-1:0]   best_idx;
    logic [SLVL_W-1:0]  best_lvl, second_lvl;

    hamming_nn_ratio_match dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_query_word0    (drv.query[63:0]),
        .i_query_word1    (drv.query[127:64]),
        .i_query_word2    (drv.query[191:128]),
        .i_query_word3    (drv.query[255:192]),
        .i_cand_word0     (drv.cand[63:0]),
        .i_cand_word1     (drv.cand[127:64]),
        .i_cand_word2     (drv.cand[191:128]),
        .i_cand_word3     (drv.cand[255:192]),
        .i_cand_index     (drv.meta.cand_index),
        .i_cand_level     (drv.meta.cand_level),
        .i_cand_skip      (drv.meta.cand_skip),
        .i_last_candidate (drv.meta.last_candidate),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_match_found    (o_match_found),
        .o_best_index     (o_best_index),
        .o_best_distance  (o_best_distance),
        .o_second_distance(o_second_distance),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_idx),
        .i_cfg_data       (cfg_dat)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_search();
        best_d     = NO_DIST;
        second_d   = NO_DIST;
        best_idx   = '0;
        best_lvl   = NONE_LEVEL;
        second_lvl = NONE_LEVEL;
    endfunction

    // returns 1 when the beat closes a query, with the judged match in r
    function automatic bit track_candidate(input t_cand_beat b, output t_result r);
        logic [DIST_W-1:0] d;
        int lhs, rhs;
        bit ok;
        r = '0;
        if (!b.meta.cand_skip) begin
            d = DIST_W'($countones(b.query ^ b.cand));
            if (d < best_d) begin
                second_d   = best_d;
                second_lvl = best_lvl;
                best_d     = d;
                best_lvl   = {1'b0, b.meta.cand_level};
                best_idx   = b.meta.cand_index;
            end else if (d < second_d) begin
                second_d   = d;
                second_lvl = {1'b0, b.meta.cand_level};
            end
        end
        if (!b.meta.last_candidate)
            return 1'b0;
        lhs = int'(best_d) * 256;
        rhs = int'(ratio_cfg) * int'(second_d);
        ok = (best_d < NO_DIST) && (best_d <= lim_cfg);
        if (ok) begin
            if (rule_cfg == RULE_STRICT)
                ok = lhs < rhs;
            else if (best_lvl == second_lvl && lhs > rhs)
                ok = 1'b0;
        end
        r.match_found     = ok;
        r.best_index      = ok ? best_idx : '0;
        r.best_distance   = best_d;
        r.second_distance = second_d;
        clear_search();
        return 1'b1;
    endfunction

    function automatic logic [DESC_W-1:0] rand_desc();
        logic [DESC_W-1:0] v;
        for (int k = 0; k < DESC_W / 32; k++)
            v[k*32 +: 32] = $urandom;
        return v;
    endfunction

    // mask with exactly n distinct bits set
    function automatic logic [DESC_W-1:0] bits_set(input int n);
        logic [DESC_W-1:0] m;
        int cnt, pos;
        m = '0;
        cnt = 0;
        while (cnt < n) begin
            pos = $urandom_range(DESC_W - 1);
            if (!m[pos]) begin
                m[pos] = 1'b1;
                cnt++;
            end
        end
        return m;
    endfunction

    function automatic void push_beat(input logic [DESC_W-1:0] q, input int d, input int idx,
                                      input int lvl, input bit skip, input bit last);
        t_cand_beat b;
        b.query               = q;
        b.cand                = q ^ bits_set(d);
        b.meta.cand_index     = IDX_W'(idx);
        b.meta.cand_level     = LVL_W'(lvl);
        b.meta.cand_skip      = skip;
        b.meta.last_candidate = last;
        cand_beats = {cand_beats, b};
    endfunction

    // one query: a short run of candidates, ties and near-threshold distances mixed in
    function automatic int queue_query_group();
        logic [DESC_W-1:0] q;
        t_cand_beat b;
        int n, d, prev_d, r;
        logic [LVL_W-1:0] base_lvl;
        q = rand_desc();
        n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        base_lvl = LVL_W'($urandom_range(15));
        prev_d = $urandom_range(60);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 40)
                d = $urandom_range(40);
            else if (r < 60)
                d = $urandom_range(41, 120);
            else if (r < 70)
                d = $urandom_range(256);
            else if (r < 78)
                d = 256;
            else if (r < 92)
                d = prev_d;
            else
                d = -1;
            if (d < 0) begin
                b.query = rand_desc();
                b.cand  = rand_desc();
            end else begin
                b.query = q;
                b.cand  = q ^ bits_set(d);
                prev_d  = d;
            end
            b.meta.cand_index     = IDX_W'($urandom_range(4095));
            b.meta.cand_level     = $urandom_range(1) ? base_lvl : LVL_W'($urandom_range(15));
            b.meta.cand_skip      = ($urandom_range(99) < 12);
            b.meta.last_candidate = (k == n - 1);
            cand_beats = {cand_beats, b};
        end
        return n;
    endfunction

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_dat   <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DIST_LIMIT: lim_cfg   = val;
            CFG_RATIO_Q8:   ratio_cfg = val;
            CFG_RATIO_RULE: rule_cfg  = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cand_beats.size() != 0 || in_valid || want_matches.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t mismatch %s exp %0d act %0d", $time, name, exp_v, act_v);
        end
    endtask

    // driver: predicts each accepted beat, then offers the next one
    always @(posedge i_clk) begin
        t_result r;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                if (track_candidate(drv, r))
                    want_matches = {want_matches, r};
            end
            if (!in_valid || !o_in_stall) begin
                if (cand_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
                    drv      <= cand_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_result w;
        if (rst_n && o_out_valid && !out_stall) begin
            if (want_matches.size() == 0) begin
                errors++;
                $display("%0t unexpected result beat, match %0b idx %0d best %0d second %0d",
                         $time, o_match_found, o_best_index, o_best_distance,
                         o_second_distance);
            end else begin
                w = want_matches.pop_front();
                check_field("match_found", 16'(w.match_found), 16'(o_match_found));
                check_field("best_index", 16'(w.best_index), 16'(o_best_index));
                check_field("best_distance", 16'(w.best_distance), 16'(o_best_distance));
                check_field("second_distance", 16'(w.second_distance),
                            16'(o_second_distance));
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_stall);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [DESC_W-1:0] q;
        int added;
        clear_search();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed, reset config: limit 100, ratio 230, strict
        push_beat('0, 0, 4095, 15, 1'b0, 1'b1);          // identical, max index and level
        push_beat('1, 256, 0, 0, 1'b0, 1'b1);            // all bits differ, never enters
        push_beat('1, 0, 7, 3, 1'b1, 1'b1);              // lone skipped last
        q = rand_desc();
        push_beat(q, 10, 1, 3, 1'b0, 1'b0);
        push_beat(q, 10, 2, 3, 1'b0, 1'b0);              // tie keeps the first
        push_beat(q, 5, 3, 2, 1'b0, 1'b0);
        push_beat(q, 200, 4, 2, 1'b0, 1'b1);
        push_beat(q, 40, 5, 1, 1'b0, 1'b0);
        push_beat(q, 0, 6, 1, 1'b1, 1'b1);               // better but skipped last
        push_beat(q, 100, 8, 0, 1'b0, 1'b1);             // right at the limit
        push_beat(q, 101, 9, 0, 1'b0, 1'b1);             // one past the limit
        push_beat(q, 20, 10, 6, 1'b0, 1'b0);
        push_beat(q, 21, 11, 6, 1'b0, 1'b1);             // ratio too close
        push_beat(q, 21, 12, 6, 1'b0, 1'b0);
        push_beat(q, 20, 13, 6, 1'b0, 1'b1);             // old best drops to second
        wait_idle();

        write_reg(CFG_DIST_LIMIT, 9'd40);
        write_reg(CFG_RATIO_Q8, 9'd128);
        write_reg(CFG_RATIO_RULE, CDATA_W'(RULE_LEVEL));
        push_beat(q, 10, 20, 5, 1'b0, 1'b0);
        push_beat(q, 20, 21, 5, 1'b0, 1'b1);             // ratio exactly equal, same level
        push_beat(q, 11, 22, 5, 1'b0, 1'b0);
        push_beat(q, 20, 23, 5, 1'b0, 1'b1);             // ratio fails, same level
        push_beat(q, 11, 24, 4, 1'b0, 1'b0);
        push_beat(q, 20, 25, 5, 1'b0, 1'b1);             // ratio fails, levels differ
        push_beat(q, 40, 26, 0, 1'b0, 1'b1);             // no second
        push_beat(q, 41, 27, 0, 1'b0, 1'b1);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_DIST_LIMIT, 9'd0);
                    write_reg(CFG_RATIO_Q8, 9'd0);
                    write_reg(CFG_RATIO_RULE, CDATA_W'(RULE_STRICT));
                end
                1: begin
                    write_reg(CFG_DIST_LIMIT, 9'd256);
                    write_reg(CFG_RATIO_Q8, 9'd256);
                    write_reg(CFG_RATIO_RULE, CDATA_W'(RULE_LEVEL));
                end
                2: begin
                    write_reg(CFG_DIST_LIMIT, 9'd511);
                    write_reg(CFG_RATIO_Q8, 9'd511);
                    write_reg(CFG_RATIO_RULE, CDATA_W'(RULE_STRICT));
                end
                3: begin
                    write_reg(CFG_DIST_LIMIT, 9'd60);
                    write_reg(CFG_RATIO_Q8, 9'd200);
                    write_reg(CFG_RATIO_RULE, CDATA_W'(RULE_LEVEL));
                end
                4: begin
                    write_reg(CFG_DIST_LIMIT, CDATA_W'($urandom_range(511)));
                    write_reg(CFG_RATIO_Q8, CDATA_W'($urandom_range(511)));
                    write_reg(CFG_RATIO_RULE, CDATA_W'($urandom_range(1)));
                end
                default: begin
                    write_reg(CFG_DIST_LIMIT, DIST_LIMIT_RST);
                    write_reg(CFG_RATIO_Q8, RATIO_Q8_RST);
                    write_reg(CFG_RATIO_RULE, CDATA_W'(RULE_STRICT));
                end
            endcase
            // idle mix cycles: receiver-heavy gaps, sender-heavy gaps, none
            case (p % 3)
                0: begin send_idle = 35; recv_stall = 60; end
                1: begin send_idle = 60; recv_stall = 35; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            added = 0;
            while (added < PHASE_BEATS / 2)
                added += queue_query_group();
            // sender holds off until every result is back
            if (p % 3 == 2)
                wait_idle();
            while (added < PHASE_BEATS)
                added += queue_query_group();
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
